>>> hw/rtl/ech_pkg.sv
// Types, constants and helper functions shared by the epoch credit history block.
package ech_pkg;

  localparam int unsigned HISTORY_DEPTH = 64;
  localparam int unsigned SLOTS         = HISTORY_DEPTH + 1;
  localparam int unsigned SLOT_W        = $clog2(SLOTS);
  localparam int unsigned CNT_W         = $clog2(SLOTS + 1);
  localparam int unsigned PADDR_W       = 4;
  localparam int unsigned PDATA_W       = 64;

  localparam logic [63:0] ALL_ONES = '1;

  localparam logic [1:0] KIND_INC   = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [2:0] ACT_ACCUM   = 3'd0;
  localparam logic [2:0] ACT_REUSE   = 3'd1;
  localparam logic [2:0] ACT_APPEND  = 3'd2;
  localparam logic [2:0] ACT_AFTER_M = 3'd3;
  localparam logic [2:0] ACT_LOAD    = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;
  localparam logic [2:0] ACT_CLEAR   = 3'd6;
  localparam logic [2:0] ACT_IGNORE  = 3'd7;

  localparam logic [PADDR_W-1:0] ADDR_MIG_EPOCH = PADDR_W'(0);

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] epoch;
    logic [63:0] credits;
    logic [63:0] prior_credits;
    logic [6:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] entry_epoch;
    logic [63:0] entry_credits;
    logic [63:0] entry_prior_credits;
    logic [6:0]  entry_count;
    logic        marker_inserted;
    logic        head_dropped;
  } out_item_t;

  typedef struct packed {
    logic [63:0] epoch;
    logic [63:0] credits;
    logic [63:0] prior_credits;
  } entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  total;
    logic              dropped;
  } push_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  // Ring position of the entry that lies pos places after the head.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
    if (s >= (CNT_W + 1)'(SLOTS)) begin
      s = s - (CNT_W + 1)'(SLOTS);
    end
    return SLOT_W'(s);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] head);
    return (head == SLOT_W'(SLOTS - 1)) ? '0 : head + SLOT_W'(1);
  endfunction

  // Append at the tail: a full ring loses its head first, and with trim set
  // the history is cut back to HISTORY_DEPTH entries afterwards.
  function automatic push_t push_calc(input logic [SLOT_W-1:0] head,
                                      input logic [CNT_W-1:0] total,
                                      input logic trim);
    push_t r;
    logic [SLOT_W-1:0] h1;
    logic [CNT_W-1:0]  t1;
    r.dropped = 1'b0;
    h1 = head;
    t1 = total;
    if (total >= CNT_W'(SLOTS)) begin
      h1 = slot_inc(head);
      t1 = total - CNT_W'(1);
      r.dropped = 1'b1;
    end
    r.slot = slot_of(h1, t1);
    t1 = t1 + CNT_W'(1);
    if (trim && (t1 > CNT_W'(HISTORY_DEPTH))) begin
      h1 = slot_inc(h1);
      t1 = t1 - CNT_W'(1);
      r.dropped = 1'b1;
    end
    r.head  = h1;
    r.total = t1;
    return r;
  endfunction

endpackage

>>> hw/rtl/ech_in_if.sv
// Valid/ready channel that carries one input item.
interface ech_in_if;
  logic              valid;
  logic              ready;
  ech_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ech_out_if.sv
// Valid/ready channel that carries one result item.
interface ech_out_if;
  logic               valid;
  logic               ready;
  ech_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ech_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ech_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/epoch_credit_history_update_unit.sv
// Top level of the epoch credit history block: sequencer around one history RAM.
//
//  port      dir  kind        content
//  in_i      in   valid/ready kind, epoch, credits, prior_credits, entry_index
//  out_o     out  valid/ready action, tail or read entry, count, marker, dropped
//  psel..    in   APB         migration epoch register at byte address 0 (64-bit data)
//
// An increment in the migration epoch adds a marker search, which reads one RAM
// entry per cycle through the single read port.
// After reset the history is empty and the migration epoch register is all ones.
// A new item is taken only in the idle state; a result that is not yet
// taken stalls the sequencer in its final state and nothing is lost.
module epoch_credit_history_update_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ech_in_if.sink                      in_i,
  ech_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ech_pkg::PADDR_W-1:0] paddr,
  input  logic [ech_pkg::PDATA_W-1:0] pwdata,
  output logic [ech_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ech_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_TAIL_RD  = 3'd2;
  localparam logic [2:0] ST_TAIL_CHK = 3'd3;
  localparam logic [2:0] ST_SEED_CHK = 3'd4;
  localparam logic [2:0] ST_OUT_RD   = 3'd5;
  localparam logic [2:0] ST_OUT_CAP  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic              scan_pend_q, scan_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       mig_q;

  logic [63:0]       ep_q, ep_d;
  logic [63:0]       cr_q, cr_d;
  logic [6:0]        idx_q, idx_d;
  logic [2:0]        action_q, action_d;
  logic              marker_q, marker_d;
  logic              dropped_q, dropped_d;
  out_item_t         out_q, out_d;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  entry_t            rd_entry;

  logic              in_fire;
  logic              cfg_write;
  push_t             push_r;
  push_t             push_nt;
  logic [SLOT_W-1:0] tail_slot;
  logic [SLOT_W-1:0] out_slot;
  logic [63:0]       tail_sum;

  ech_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr == ADDR_MIG_EPOCH) ? mig_q : '0;

  // Push with trim serves increments, push without trim serves loads and the marker insertion.
  assign push_r    = push_calc(head_q, total_q, 1'b1);
  assign push_nt   = push_calc(head_q, total_q, 1'b0);
  assign tail_slot = slot_of(head_q, total_q - CNT_W'(1));
  assign out_slot  = (action_q == ACT_READ) ? slot_of(head_q, CNT_W'(idx_q)) : tail_slot;
  assign tail_sum  = sat_add(rd_entry.credits, cr_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    total_d     = total_q;
    scan_idx_d  = scan_idx_q;
    scan_pend_d = scan_pend_q;
    out_valid_d = out_valid_q;
    ep_d        = ep_q;
    cr_d        = cr_q;
    idx_d       = idx_q;
    action_d    = action_q;
    marker_d    = marker_q;
    dropped_d   = dropped_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ep_d        = in_i.data.epoch;
          cr_d        = in_i.data.credits;
          idx_d       = in_i.data.entry_index;
          marker_d    = 1'b0;
          dropped_d   = 1'b0;
          scan_idx_d  = '0;
          scan_pend_d = 1'b0;
          unique case (in_i.data.kind)
            KIND_INC: begin
              if (in_i.data.credits == 64'd0) begin
                action_d = ACT_IGNORE;
                state_d  = ST_OUT_RD;
              end else if (in_i.data.epoch == mig_q) begin
                state_d = ST_SCAN;
              end else begin
                state_d = ST_TAIL_RD;
              end
            end
            KIND_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = push_nt.slot;
              ram_wdata = '{epoch: in_i.data.epoch, credits: in_i.data.credits,
                            prior_credits: in_i.data.prior_credits};
              head_d    = push_nt.head;
              total_d   = push_nt.total;
              dropped_d = push_nt.dropped;
              action_d  = ACT_LOAD;
              state_d   = ST_OUT_RD;
            end
            KIND_READ: begin
              action_d = (32'(in_i.data.entry_index) < 32'(total_q)) ? ACT_READ : ACT_IGNORE;
              state_d  = ST_OUT_RD;
            end
            KIND_CLEAR: begin
              head_d   = '0;
              total_d  = '0;
              action_d = ACT_CLEAR;
              state_d  = ST_OUT_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // One read issued per cycle; the data of the previous read is checked.
      ST_SCAN: begin
        if (scan_pend_q && (rd_entry.epoch == ALL_ONES)) begin
          state_d = ST_TAIL_RD;
        end else if (scan_idx_q < total_q) begin
          ram_raddr   = slot_of(head_q, scan_idx_q);
          scan_idx_d  = scan_idx_q + CNT_W'(1);
          scan_pend_d = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = push_nt.slot;
          ram_wdata = '{epoch: ALL_ONES, credits: ALL_ONES, prior_credits: ALL_ONES};
          head_d    = push_nt.head;
          total_d   = push_nt.total;
          dropped_d = dropped_q | push_nt.dropped;
          marker_d  = 1'b1;
          state_d   = ST_TAIL_RD;
        end
      end

      ST_TAIL_RD: begin
        if (total_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = push_r.slot;
          ram_wdata = '{epoch: ep_q, credits: cr_q, prior_credits: 64'd0};
          head_d    = push_r.head;
          total_d   = push_r.total;
          dropped_d = dropped_q | push_r.dropped;
          action_d  = ACT_APPEND;
          state_d   = ST_OUT_RD;
        end else begin
          ram_raddr = tail_slot;
          state_d   = ST_TAIL_CHK;
        end
      end

      ST_TAIL_CHK: begin
        state_d = ST_OUT_RD;
        if (rd_entry.epoch == ALL_ONES) begin
          if (total_q >= CNT_W'(2)) begin
            ram_raddr = slot_of(head_q, total_q - CNT_W'(2));
            state_d   = ST_SEED_CHK;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = push_r.slot;
            ram_wdata = '{epoch: ep_q, credits: cr_q, prior_credits: 64'd0};
            head_d    = push_r.head;
            total_d   = push_r.total;
            dropped_d = dropped_q | push_r.dropped;
            action_d  = ACT_AFTER_M;
          end
        end else if (rd_entry.epoch == ep_q) begin
          ram_we    = 1'b1;
          ram_waddr = tail_slot;
          ram_wdata = '{epoch: rd_entry.epoch, credits: tail_sum,
                        prior_credits: rd_entry.prior_credits};
          action_d  = ACT_ACCUM;
        end else if (rd_entry.credits == rd_entry.prior_credits) begin
          // A tail that earned nothing is taken over by the new epoch.
          ram_we    = 1'b1;
          ram_waddr = tail_slot;
          ram_wdata = '{epoch: ep_q, credits: tail_sum,
                        prior_credits: rd_entry.prior_credits};
          action_d  = ACT_REUSE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = push_r.slot;
          ram_wdata = '{epoch: ep_q, credits: tail_sum, prior_credits: rd_entry.credits};
          head_d    = push_r.head;
          total_d   = push_r.total;
          dropped_d = dropped_q | push_r.dropped;
          action_d  = ACT_APPEND;
        end
      end

      // The entry before the marker seeds the new one.
      ST_SEED_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = push_r.slot;
        ram_wdata = '{epoch: ep_q, credits: tail_sum, prior_credits: rd_entry.credits};
        head_d    = push_r.head;
        total_d   = push_r.total;
        dropped_d = dropped_q | push_r.dropped;
        action_d  = ACT_AFTER_M;
        state_d   = ST_OUT_RD;
      end

      ST_OUT_RD: begin
        ram_raddr = out_slot;
        state_d   = ST_OUT_CAP;
      end

      // The read address is held so the RAM data stays put while stalled.
      ST_OUT_CAP: begin
        ram_raddr = out_slot;
        if (!out_valid_q || out_o.ready) begin
          out_d.action          = action_q;
          out_d.entry_count     = 7'(total_q);
          out_d.marker_inserted = marker_q;
          out_d.head_dropped    = dropped_q;
          if ((action_q == ACT_READ) || (total_q != '0)) begin
            out_d.entry_epoch         = rd_entry.epoch;
            out_d.entry_credits       = rd_entry.credits;
            out_d.entry_prior_credits = rd_entry.prior_credits;
          end else begin
            out_d.entry_epoch         = '0;
            out_d.entry_credits       = '0;
            out_d.entry_prior_credits = '0;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      total_q     <= '0;
      scan_idx_q  <= '0;
      scan_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      mig_q       <= ALL_ONES;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      total_q     <= total_d;
      scan_idx_q  <= scan_idx_d;
      scan_pend_q <= scan_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_write && (paddr == ADDR_MIG_EPOCH)) begin
        mig_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ep_q      <= ep_d;
    cr_q      <= cr_d;
    idx_q     <= idx_d;
    action_q  <= action_d;
    marker_q  <= marker_d;
    dropped_q <= dropped_d;
    out_q     <= out_d;
  end

endmodule

>>> dv/epoch_credit_history_update_unit_test.sv
// Self-checking testbench for the epoch credit history block: directed and random item traffic.
module epoch_credit_history_update_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ech_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 6_000_000;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ech_in_if  in_if ();
  ech_out_if out_if ();

  epoch_credit_history_update_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the history ring and the migration register.
  logic [63:0] hist_ep_q [SLOTS];
  logic [63:0] hist_cr_q [SLOTS];
  logic [63:0] hist_pc_q [SLOTS];
  int unsigned ring_head;
  int unsigned ring_count;
  logic [63:0] mig_epoch;
  bit          dropped_flag;
  bit          marker_flag;

  out_item_t   pending_results[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned markers_seen;
  int unsigned drops_seen;
  int unsigned settings_used;
  bit          steady;
  int unsigned out_hold;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s < a) ? ALL_ONES : s;
  endfunction

  function automatic int unsigned ring_slot(input int unsigned pos);
    return (ring_head + pos) % SLOTS;
  endfunction

  function automatic void drop_oldest();
    if (ring_count == 0) return;
    ring_head    = (ring_head + 1) % SLOTS;
    ring_count   = ring_count - 1;
    dropped_flag = 1'b1;
  endfunction

  function automatic void append_entry(input logic [63:0] e, input logic [63:0] c,
                                       input logic [63:0] p);
    int unsigned s;
    if (ring_count >= SLOTS) drop_oldest();
    s = ring_slot(ring_count);
    hist_ep_q[s] = e;
    hist_cr_q[s] = c;
    hist_pc_q[s] = p;
    ring_count   = ring_count + 1;
  endfunction

  function automatic void cut_to_depth();
    while (ring_count > HISTORY_DEPTH) drop_oldest();
  endfunction

  function automatic bit holds_marker();
    for (int unsigned i = 0; i < ring_count; i++) begin
      if (hist_ep_q[ring_slot(i)] == ALL_ONES) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] add_credits(input logic [63:0] ep, input logic [63:0] cr);
    int unsigned t;
    logic [63:0] seed;
    logic [63:0] fin;
    if (ep == mig_epoch && !holds_marker()) begin
      append_entry(ALL_ONES, ALL_ONES, ALL_ONES);
      marker_flag = 1'b1;
    end
    if (ring_count == 0) begin
      append_entry(ep, cr, '0);
      return ACT_APPEND;
    end
    t = ring_slot(ring_count - 1);
    if (hist_ep_q[t] == ALL_ONES) begin
      // The new entry continues from the one that preceded the marker.
      seed = '0;
      if (ring_count >= 2) seed = hist_cr_q[ring_slot(ring_count - 2)];
      append_entry(ep, add_clamped(cr, seed), seed);
      cut_to_depth();
      return ACT_AFTER_M;
    end
    if (hist_ep_q[t] == ep) begin
      hist_cr_q[t] = add_clamped(hist_cr_q[t], cr);
      return ACT_ACCUM;
    end
    if (hist_cr_q[t] == hist_pc_q[t]) begin
      hist_ep_q[t] = ep;
      hist_cr_q[t] = add_clamped(hist_cr_q[t], cr);
      return ACT_REUSE;
    end
    fin = hist_cr_q[t];
    append_entry(ep, add_clamped(cr, fin), fin);
    cut_to_depth();
    return ACT_APPEND;
  endfunction

  function automatic out_item_t predict_history_result(input in_item_t it);
    out_item_t   r;
    int unsigned pick;
    bit          shown;
    r            = '0;
    pick         = 0;
    shown        = 1'b0;
    dropped_flag = 1'b0;
    marker_flag  = 1'b0;
    r.action     = ACT_IGNORE;
    case (it.kind)
      KIND_INC: begin
        if (it.credits != '0) r.action = add_credits(it.epoch, it.credits);
      end
      KIND_LOAD: begin
        append_entry(it.epoch, it.credits, it.prior_credits);
        r.action = ACT_LOAD;
      end
      KIND_READ: begin
        if (it.entry_index < ring_count) begin
          pick     = ring_slot(it.entry_index);
          shown    = 1'b1;
          r.action = ACT_READ;
        end
      end
      default: begin
        ring_count = 0;
        ring_head  = 0;
        r.action   = ACT_CLEAR;
      end
    endcase
    if (!shown && ring_count > 0) begin
      pick  = ring_slot(ring_count - 1);
      shown = 1'b1;
    end
    if (shown) begin
      r.entry_epoch         = hist_ep_q[pick];
      r.entry_credits       = hist_cr_q[pick];
      r.entry_prior_credits = hist_pc_q[pick];
    end
    r.entry_count     = 7'(ring_count);
    r.marker_inserted = marker_flag;
    r.head_dropped    = dropped_flag;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (got.marker_inserted === 1'b1) markers_seen++;
    if (got.head_dropped === 1'b1) drops_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("action", want.action, got.action);
    compare_field("entry_epoch", want.entry_epoch, got.entry_epoch);
    compare_field("entry_credits", want.entry_credits, got.entry_credits);
    compare_field("entry_prior_credits", want.entry_prior_credits, got.entry_prior_credits);
    compare_field("entry_count", want.entry_count, got.entry_count);
    compare_field("marker_inserted", want.marker_inserted, got.marker_inserted);
    compare_field("head_dropped", want.head_dropped, got.head_dropped);
  endfunction

  // Result side: after each transfer, hold ready low for a drawn number of cycles
  // counted while a result is offered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        check_result(out_if.data);
        out_hold = steady ? 0 : $urandom_range(0, 9);
      end else if (out_if.valid && out_hold > 0) begin
        out_hold = out_hold - 1;
      end
      out_if.ready <= (out_hold == 0);
    end
  end

  function automatic in_item_t make_item(input logic [1:0] kind, input logic [63:0] ep,
                                         input logic [63:0] cr, input logic [63:0] pc,
                                         input logic [6:0] idx);
    in_item_t it;
    it.kind          = kind;
    it.epoch         = ep;
    it.credits       = cr;
    it.prior_credits = pc;
    it.entry_index   = idx;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Valid stays high after a transfer so that a following item with no gap
  // goes out without a bubble; in_idle lowers it when the stream stops.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_history_result(it));
    items_sent++;
  endtask

  task automatic in_idle();
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    in_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MIG_EPOCH) mig_epoch = value;
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr, input logic [63:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    compare_field("prdata", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_migration(input logic [63:0] value);
    wait_for_results();
    apb_write(ADDR_MIG_EPOCH, value);
    @(posedge clk_i);
    apb_read_check(ADDR_MIG_EPOCH, value);
    settings_used++;
  endtask

  function automatic logic [63:0] rand_credits();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 20) return ALL_ONES - 64'($urandom_range(0, 3));
    if (r < 40) return rand64();
    return 64'($urandom_range(1, 1000));
  endfunction

  // Accumulate, reuse, append, saturation, loads, reads in and out of range, clear,
  // and the marker that an all-ones epoch inserts while the register is all ones.
  task automatic test_history_basics();
    apb_read_check(ADDR_MIG_EPOCH, ALL_ONES);
    send_item(make_item(KIND_READ, '0, '0, '0, 7'd0));
    send_item(make_item(KIND_INC, 64'd5, '0, '0, '0));
    send_item(make_item(KIND_INC, 64'd5, 64'd10, '0, '0));
    send_item(make_item(KIND_INC, 64'd5, ALL_ONES, ALL_ONES, '0));
    send_item(make_item(KIND_INC, 64'd6, 64'd1, '0, '0));
    send_item(make_item(KIND_INC, 64'd7, 64'd3, '0, '0));
    send_item(make_item(KIND_LOAD, 64'd9, 64'd4, 64'd4, '0));
    send_item(make_item(KIND_INC, 64'd10, 64'd2, '0, '0));
    send_item(make_item(KIND_LOAD, '0, '0, '0, '0));
    send_item(make_item(KIND_LOAD, 64'd11, 64'd5, ALL_ONES, '1));
    send_item(make_item(KIND_INC, 64'd12, 64'd1, '0, '0));
    send_item(make_item(KIND_READ, '0, '0, '0, 7'd0));
    send_item(make_item(KIND_READ, '0, '0, '0, 7'd127));
    send_item(make_item(KIND_READ, '0, '0, '0, 7'd3));
    send_item(make_item(KIND_INC, ALL_ONES, 64'd1, '0, '0));
    send_item(make_item(KIND_INC, 64'd13, 64'd7, '0, '0));
    send_item(make_item(KIND_CLEAR, '0, '0, '0, '0));
    send_item(make_item(KIND_READ, '0, '0, '0, 7'd0));
  endtask

  // Marker insertion into an empty history, a loaded marker, and the seed taken
  // from the entry that precedes the marker.
  task automatic test_marker_insertion();
    set_migration(64'd100);
    send_item(make_item(KIND_INC, 64'd100, 64'd1, '0, '0));
    send_item(make_item(KIND_INC, 64'd100, 64'd2, '0, '0));
    send_item(make_item(KIND_INC, 64'd101, 64'd3, '0, '0));
    send_item(make_item(KIND_LOAD, ALL_ONES, 64'd9, 64'd9, '0));
    send_item(make_item(KIND_INC, 64'd102, 64'd4, '0, '0));
    send_item(make_item(KIND_CLEAR, '0, '0, '0, '0));
    send_item(make_item(KIND_INC, 64'd99, 64'd1, '0, '0));
    send_item(make_item(KIND_INC, 64'd100, 64'd5, '0, '0));
    set_migration('0);
    send_item(make_item(KIND_CLEAR, '0, '0, '0, '0));
    send_item(make_item(KIND_INC, '0, ALL_ONES, '0, '0));
  endtask

  // Mostly well-formed epoch walks with random content; loads fill the ring so
  // that heads drop and trimming happens, with sparse clears and noise.
  task automatic test_random_traffic(input logic [63:0] mig, input logic [63:0] ep_base,
                                     input int unsigned n, input bit hold_off);
    in_item_t    it;
    logic [63:0] cur_ep;
    int unsigned r;
    int unsigned e;
    set_migration(mig);
    cur_ep = ep_base;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (hold_off && i == n / 2) wait_for_results();
      r = $urandom_range(0, 99);
      e = $urandom_range(0, 99);
      if (r < 55) it.kind = KIND_INC;
      else if (r < 80) it.kind = KIND_LOAD;
      else if (r < 98) it.kind = KIND_READ;
      else it.kind = KIND_CLEAR;
      if (e < 40) begin
        it.epoch = cur_ep;
      end else if (e < 75) begin
        cur_ep   = cur_ep + 64'd1;
        it.epoch = cur_ep;
      end else if (e < 85) begin
        cur_ep   = cur_ep + 64'($urandom_range(2, 5));
        it.epoch = cur_ep;
      end else if (e < 92) begin
        it.epoch = mig_epoch;
      end else if (e < 95) begin
        it.epoch = ALL_ONES;
      end else begin
        it.epoch = rand64();
      end
      it.credits       = rand_credits();
      it.prior_credits = ($urandom_range(0, 2) == 0) ? it.credits : rand_credits();
      e = $urandom_range(0, 9);
      if (e < 7) it.entry_index = 7'($urandom_range(0, ring_count));
      else it.entry_index = 7'($urandom_range(0, 127));
      send_item(it);
    end
    steady = 1'b0;
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_ni       = 1'b0;
    steady       = 1'b0;
    out_hold     = 0;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    markers_seen = 0;
    drops_seen   = 0;
    settings_used = 0;
    ring_head    = 0;
    ring_count   = 0;
    mig_epoch    = ALL_ONES;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      hist_ep_q[i] = '0;
      hist_cr_q[i] = '0;
      hist_pc_q[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_history_basics();
    test_marker_insertion();
    test_random_traffic(ALL_ONES, ALL_ONES - 64'd100, 195, 1'b0);
    test_random_traffic('0, '0, 195, 1'b0);
    test_random_traffic(64'd1000, 64'd990, 195, 1'b1);
    test_random_traffic(rand64(), rand64(), 195, 1'b0);

    wait_for_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items over %0d migration epoch settings; checked %0d results.",
             items_sent, settings_used, results_seen);
    $display("Results showed %0d marker insertions and %0d head drops.",
             markers_seen, drops_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Timeout with %0d results still expected.", pending_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule
